### rtl/ime_pkg.sv
// ----------------------------------------------------------------------------
// ime_pkg
// Shared widths, register indexes and reset constants of the Ising engine.
// ----------------------------------------------------------------------------
package ime_pkg;

    localparam int SITE_W      = 12;
    localparam int FRAC_W      = 32;
    localparam int MAG_W       = 14;
    localparam int BOND_W      = 15;
    localparam int CFG_INDEX_W = 2;

    // Reciprocal for the site / SIDE split: quotient = (site * RECIP) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 23;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [FRAC_W-1:0] THR_LOW_RESET  = 32'd736940000;
    localparam logic [FRAC_W-1:0] THR_HIGH_RESET = 32'd126440000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THR_LOW  = 2'd0,
        CFG_THR_HIGH = 2'd1,
        CFG_COUPLING = 2'd2
    } cfg_index_t;

    // Width of one decoded request between the front end and the back end
    function automatic int work_width(input int side);
        return 3 + FRAC_W + 2 * $clog2(side);
    endfunction

endpackage

### rtl/ime_if.sv
// ----------------------------------------------------------------------------
// ime_if
// Valid/ready channels of the Ising engine: requests, results, configuration.
// ----------------------------------------------------------------------------
interface ime_item_if import ime_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [SITE_W-1:0] site;
    logic              spin_value;
    logic [FRAC_W-1:0] random_fraction;

    modport source (output valid, op, site, spin_value, random_fraction, input ready);
    modport sink   (input valid, op, site, spin_value, random_fraction, output ready);
endinterface

interface ime_result_if import ime_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     flipped;
    logic signed [MAG_W-1:0]  magnetisation_sum;
    logic signed [BOND_W-1:0] bond_sum;

    modport source (output valid, flipped, magnetisation_sum, bond_sum, input ready);
    modport sink   (input valid, flipped, magnetisation_sum, bond_sum, output ready);
endinterface

interface ime_cfg_if import ime_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [FRAC_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ime_front.sv
// ----------------------------------------------------------------------------
// ime_front
// Accepts requests and splits the site into row and column, flags sites
// outside the lattice, and pushes the decoded request into the queue.
// ----------------------------------------------------------------------------
module ime_front import ime_pkg::*; #(
    parameter int SIDE = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ime_item_if.sink                    items,
    input  logic                        clearing,
    input  logic                        q_full,
    output logic                        push,
    output logic [work_width(SIDE)-1:0] push_data
);

    localparam int ROW_W  = $clog2(SIDE);
    localparam int PROD_W = SITE_W + RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / SIDE);
    localparam logic [SITE_W:0]    SIDE_X = (SITE_W + 1)'(SIDE);

    typedef struct packed {
        logic              in_range;
        logic              op;
        logic              spin_value;
        logic [FRAC_W-1:0] random_fraction;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
    } work_t;

    logic              st_valid_reg;
    logic              st_op_reg;
    logic [SITE_W-1:0] st_site_reg;
    logic              st_spin_reg;
    logic [FRAC_W-1:0] st_frac_reg;
    logic [SITE_W-1:0] st_quot_reg;

    logic [PROD_W-1:0] prod;
    logic [SITE_W-1:0] quot_est;
    logic [SITE_W:0]   back_mul;
    logic [SITE_W:0]   rem;
    logic [SITE_W:0]   rem_fix;
    logic [SITE_W:0]   quot_fix;
    logic              accept;
    work_t             work;

    assign items.ready = !clearing && (!st_valid_reg || !q_full);
    assign accept      = items.valid && items.ready;
    assign push        = st_valid_reg && !q_full;

    // Quotient estimate is exact or one low
    always_comb
    begin
        prod     = PROD_W'(items.site) * PROD_W'(RECIP);
        quot_est = prod[RECIP_SHIFT +: SITE_W];
    end

    always_comb
    begin
        back_mul = (SITE_W + 1)'(st_quot_reg) * SIDE_X;
        rem      = {1'b0, st_site_reg} - back_mul;
        if (rem >= SIDE_X)
        begin
            rem_fix  = rem - SIDE_X;
            quot_fix = {1'b0, st_quot_reg} + (SITE_W + 1)'(1);
        end
        else
        begin
            rem_fix  = rem;
            quot_fix = {1'b0, st_quot_reg};
        end
        work.in_range        = quot_fix < SIDE_X;
        work.op              = st_op_reg;
        work.spin_value      = st_spin_reg;
        work.random_fraction = st_frac_reg;
        work.row             = quot_fix[ROW_W-1:0];
        work.col             = rem_fix[ROW_W-1:0];
        push_data            = work;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            st_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_op_reg   <= items.op;
            st_site_reg <= items.site;
            st_spin_reg <= items.spin_value;
            st_frac_reg <= items.random_fraction;
            st_quot_reg <= quot_est;
        end
    end

endmodule

### rtl/ime_queue.sv
// ----------------------------------------------------------------------------
// ime_queue
// Short FIFO between the decode front end and the lattice back end.
// ----------------------------------------------------------------------------
module ime_queue import ime_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/ime_back.sv
// ----------------------------------------------------------------------------
// ime_back
// Lattice store, Metropolis decision, running totals, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
module ime_back import ime_pkg::*; #(
    parameter int SIDE = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [work_width(SIDE)-1:0] pop_data,
    input  logic                        q_empty,
    output logic                        pop,
    output logic                        clearing,
    ime_cfg_if.sink                     cfg,
    ime_result_if.source                results
);

    localparam int ROW_W = $clog2(SIDE);
    localparam logic [ROW_W-1:0]  LAST_IDX  = ROW_W'(SIDE - 1);
    localparam logic [SIDE-1:0]   BIT0      = SIDE'(1);
    localparam logic [MAG_W-1:0]  MAG_RESET  = MAG_W'(SIDE * SIDE);
    localparam logic [BOND_W-1:0] BOND_RESET = BOND_W'(2 * SIDE * SIDE);

    typedef struct packed {
        logic              in_range;
        logic              op;
        logic              spin_value;
        logic [FRAC_W-1:0] random_fraction;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
    } work_t;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_UP    = 5'b00100,
        ST_CUR   = 5'b01000,
        ST_EVAL  = 5'b10000
    } state_t;

    // One memory word holds a whole lattice row
    logic [SIDE-1:0] lattice_mem [SIDE];
    logic [SIDE-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              flipped_reg, flipped_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [BOND_W-1:0] bond_reg, bond_next;
    logic [FRAC_W-1:0] thr_low_reg;
    logic [FRAC_W-1:0] thr_high_reg;
    logic              coupling_neg_reg;
    work_t             work_reg;
    logic              up_bit_reg;
    logic [SIDE-1:0]   cur_row_reg;

    work_t             head;
    logic              out_free;
    logic              load_work;
    logic              rd_en;
    logic [ROW_W-1:0]  rd_addr;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_addr;
    logic [SIDE-1:0]   wr_data;

    logic              s_bit;
    logic              left_bit;
    logic              right_bit;
    logic              down_bit;
    logic [2:0]        up_count;
    logic signed [4:0] nsum;
    logic signed [4:0] p_val;
    logic signed [4:0] e_val;
    logic              accept_trial;
    logic              do_flip;
    logic [BOND_W-1:0] p_ext;

    function automatic logic [ROW_W-1:0] idx_dec(input logic [ROW_W-1:0] x);
        return (x == '0) ? LAST_IDX : x - ROW_W'(1);
    endfunction

    function automatic logic [ROW_W-1:0] idx_inc(input logic [ROW_W-1:0] x);
        return (x == LAST_IDX) ? '0 : x + ROW_W'(1);
    endfunction

    assign head     = work_t'(pop_data);
    assign out_free = !out_valid_reg || results.ready;
    assign clearing = state_reg == ST_CLEAR;

    assign results.valid             = out_valid_reg;
    assign results.flipped           = flipped_reg;
    // Totals only move when a result is loaded, so they double as the payload
    assign results.magnetisation_sum = $signed(mag_reg);
    assign results.bond_sum          = $signed(bond_reg);

    assign cfg.ready = 1'b1;

    // Metropolis decision on the gathered neighborhood
    always_comb
    begin
        s_bit     = cur_row_reg[work_reg.col];
        left_bit  = cur_row_reg[idx_dec(work_reg.col)];
        right_bit = cur_row_reg[idx_inc(work_reg.col)];
        down_bit  = rd_data_reg[work_reg.col];
        up_count  = 3'(up_bit_reg) + 3'(down_bit) + 3'(left_bit) + 3'(right_bit);
        nsum      = $signed({1'b0, up_count, 1'b0}) - 5'sd4;
        p_val     = s_bit ? nsum : -nsum;
        e_val     = coupling_neg_reg ? -p_val : p_val;
        if (e_val <= 5'sd0)
        begin
            accept_trial = 1'b1;
        end
        else if (e_val == 5'sd2)
        begin
            accept_trial = work_reg.random_fraction < thr_low_reg;
        end
        else
        begin
            accept_trial = work_reg.random_fraction < thr_high_reg;
        end
        do_flip = work_reg.op ? accept_trial : (s_bit != work_reg.spin_value);
        p_ext   = BOND_W'(p_val);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !results.ready;
        flipped_next   = flipped_reg;
        mag_next       = mag_reg;
        bond_next      = bond_reg;
        pop            = 1'b0;
        load_work      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = work_reg.row;
        wr_en          = 1'b0;
        wr_addr        = work_reg.row;
        wr_data        = cur_row_reg ^ (BIT0 << work_reg.col);

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '1;
                clr_cnt_next = clr_cnt_reg + ROW_W'(1);
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head.in_range)
                    begin
                        pop        = 1'b1;
                        load_work  = 1'b1;
                        rd_en      = 1'b1;
                        rd_addr    = idx_dec(head.row);
                        state_next = ST_UP;
                    end
                    else if (out_free)
                    begin
                        // Site off the lattice: answer with the current totals
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        flipped_next   = 1'b0;
                    end
                end
            end
            ST_UP:
            begin
                rd_en      = 1'b1;
                rd_addr    = work_reg.row;
                state_next = ST_CUR;
            end
            ST_CUR:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_inc(work_reg.row);
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                // Hold until the result register frees up
                if (out_free)
                begin
                    wr_en          = do_flip;
                    out_valid_next = 1'b1;
                    flipped_next   = do_flip;
                    if (do_flip)
                    begin
                        mag_next  = s_bit ? mag_reg - MAG_W'(2) : mag_reg + MAG_W'(2);
                        bond_next = bond_reg - {p_ext[BOND_W-2:0], 1'b0};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            mag_reg       <= MAG_RESET;
            bond_reg      <= BOND_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            mag_reg       <= mag_next;
            bond_reg      <= bond_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_low_reg      <= THR_LOW_RESET;
            thr_high_reg     <= THR_HIGH_RESET;
            coupling_neg_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_THR_LOW:  thr_low_reg      <= cfg.data;
                CFG_THR_HIGH: thr_high_reg     <= cfg.data;
                CFG_COUPLING: coupling_neg_reg <= cfg.data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        flipped_reg <= flipped_next;
        if (load_work)
        begin
            work_reg <= head;
        end
        if (state_reg == ST_UP)
        begin
            up_bit_reg <= rd_data_reg[work_reg.col];
        end
        if (state_reg == ST_CUR)
        begin
            cur_row_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= lattice_mem[rd_addr];
        end
        if (wr_en)
        begin
            lattice_mem[wr_addr] <= wr_data;
        end
    end

endmodule

### rtl/ising_metropolis_engine.sv
// ----------------------------------------------------------------------------
// ising_metropolis_engine
// The front end registers and splits each accepted request and the queue buffers
// it; the back end serves lattice requests one at a time with three row reads and
// a write-back on the single-port row memory, and answers off-lattice sites from
// its totals. Reset: totals and registers return to their start values; a pass
// then sets every lattice row to +1 with items.ready held low.
// ----------------------------------------------------------------------------
module ising_metropolis_engine import ime_pkg::*; #(
    parameter int SIDE = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    ime_item_if.sink     items,
    ime_result_if.source results,
    ime_cfg_if.sink      cfg
);

    localparam int WORK_W = work_width(SIDE);

    logic              clearing;
    logic              push;
    logic [WORK_W-1:0] push_data;
    logic              pop;
    logic [WORK_W-1:0] pop_data;
    logic              q_full;
    logic              q_empty;

    ime_front #(
        .SIDE(SIDE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .clearing  (clearing),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    ime_queue #(
        .WIDTH(WORK_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    ime_back #(
        .SIDE(SIDE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (pop_data),
        .q_empty  (q_empty),
        .pop      (pop),
        .clearing (clearing),
        .cfg      (cfg),
        .results  (results)
    );

endmodule

### rtl/ime_checker.sv
// ----------------------------------------------------------------------------
// ime_port_checker
// Port-level checks of the Ising engine, bound to the top level.
// ----------------------------------------------------------------------------
module ime_port_checker import ime_pkg::*; #(
    parameter int SIDE = 64
) (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              flipped,
    input logic [MAG_W-1:0]  magnetisation_sum,
    input logic [BOND_W-1:0] bond_sum
);

    localparam logic SITES_ODD = 1'((SIDE * SIDE) % 2);
    localparam logic [MAG_W-1:0]  MAG_RESET  = MAG_W'(SIDE * SIDE);
    localparam logic [BOND_W-1:0] BOND_RESET = BOND_W'(2 * SIDE * SIDE);

    logic [3:0]        pend_reg;
    logic [MAG_W-1:0]  last_mag_reg;
    logic [BOND_W-1:0] last_bond_reg;
    logic              in_acc;
    logic              out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            last_mag_reg  <= MAG_RESET;
            last_bond_reg <= BOND_RESET;
        end
        else
        begin
            pend_reg <= pend_reg + 4'(in_acc) - 4'(out_acc);
            if (out_acc)
            begin
                last_mag_reg  <= magnetisation_sum;
                last_bond_reg <= bond_sum;
            end
        end
    end

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 4'd0)
        else $error("result without an outstanding request");

    a_parity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (magnetisation_sum[0] == SITES_ODD) && (bond_sum[0] == 1'b0))
        else $error("total parity broken");

    a_no_flip_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !flipped |->
            (magnetisation_sum == last_mag_reg) && (bond_sum == last_bond_reg))
        else $error("totals moved without a flip");

    a_flip_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && flipped |->
            (magnetisation_sum == MAG_W'(last_mag_reg + MAG_W'(2))) ||
            (magnetisation_sum == MAG_W'(last_mag_reg - MAG_W'(2))))
        else $error("flip moved magnetisation by other than two");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(flipped) && $stable(magnetisation_sum) && $stable(bond_sum))
        else $error("stalled result changed");

endmodule

bind ising_metropolis_engine ime_port_checker #(
    .SIDE(SIDE)
) u_ime_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (items.valid),
    .in_ready          (items.ready),
    .out_valid         (results.valid),
    .out_ready         (results.ready),
    .flipped           (results.flipped),
    .magnetisation_sum (results.magnetisation_sum),
    .bond_sum          (results.bond_sum)
);
